### rtl/bcpe_pkg.sv
`default_nettype none

package bcpe_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ParamW = 16;
  localparam int unsigned OneMinusW = ParamW + 1;
  localparam int unsigned WgtW = 49;
  localparam int unsigned OpndW = CoordW + 2;
  localparam int unsigned ProdW = 64;
  localparam int unsigned FracW = 48;
  localparam int unsigned NumTerms = 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW-1:0] bcoord_t;
  typedef logic [ParamW-1:0] param_t;
  typedef logic [WgtW-1:0] wgt_t;
  typedef logic [OpndW-1:0] opnd_t;
  typedef logic [ProdW-1:0] prod_t;

  // Half an LSB of the Q11.4 result, at 48 fraction bits.
  localparam prod_t RoundHalf = 64'h0000_8000_0000_0000;
  localparam bcoord_t CoordMaxBiased = 16'hFFFF;

  typedef enum logic {
    REQ_QUAD  = 1'b0,
    REQ_CUBIC = 1'b1
  } req_type_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  // Offset binary: signed value plus 32768.
  function automatic bcoord_t biased(input coord_t c);
    biased = {~c[CoordW-1], c[CoordW-2:0]};
  endfunction

  function automatic opnd_t times3(input bcoord_t b);
    times3 = {2'b00, b} + {1'b0, b, 1'b0};
  endfunction

endpackage

`default_nettype wire

### rtl/bcpe_in_if.sv
`default_nettype none

interface bcpe_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  bcpe_pkg::coord_t   start_x;
  bcpe_pkg::coord_t   start_y;
  bcpe_pkg::coord_t   ctrl_a_x;
  bcpe_pkg::coord_t   ctrl_a_y;
  bcpe_pkg::coord_t   ctrl_b_x;
  bcpe_pkg::coord_t   ctrl_b_y;
  bcpe_pkg::coord_t   end_x;
  bcpe_pkg::coord_t   end_y;
  bcpe_pkg::param_t   param_t;

  modport source (
    output valid, req_type, start_x, start_y, ctrl_a_x, ctrl_a_y,
           ctrl_b_x, ctrl_b_y, end_x, end_y, param_t,
    input  ready
  );

  modport sink (
    input  valid, req_type, start_x, start_y, ctrl_a_x, ctrl_a_y,
           ctrl_b_x, ctrl_b_y, end_x, end_y, param_t,
    output ready
  );
endinterface

`default_nettype wire

### rtl/bcpe_out_if.sv
`default_nettype none

interface bcpe_out_if;
  logic             valid;
  logic             ready;
  bcpe_pkg::coord_t point_x;
  bcpe_pkg::coord_t point_y;
  logic             clipped;

  modport source (
    output valid, point_x, point_y, clipped,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, clipped,
    output ready
  );
endinterface

`default_nettype wire

### rtl/bcpe_coord.sv
`default_nettype none

// One coordinate of the evaluator: operand prep, weighted products, sum, round, clamp.
module bcpe_coord (
  input  wire logic             clk,
  input  wire bcpe_pkg::adv_t   adv,
  input  wire logic             cubic,
  input  wire bcpe_pkg::coord_t p0,
  input  wire bcpe_pkg::coord_t pa,
  input  wire bcpe_pkg::coord_t pb,
  input  wire bcpe_pkg::coord_t p3,
  input  wire bcpe_pkg::wgt_t   wgt [bcpe_pkg::NumTerms],
  output bcpe_pkg::coord_t      coord,
  output logic                  clip
);

  bcpe_pkg::bcoord_t b0, ba, bb, b3;
  bcpe_pkg::opnd_t   m1_nxt [bcpe_pkg::NumTerms];
  bcpe_pkg::opnd_t   m1_r   [bcpe_pkg::NumTerms];
  bcpe_pkg::opnd_t   m2_r   [bcpe_pkg::NumTerms];
  bcpe_pkg::prod_t   pr_nxt [bcpe_pkg::NumTerms];
  bcpe_pkg::prod_t   pr_r   [bcpe_pkg::NumTerms];
  bcpe_pkg::prod_t   s01_nxt, s23_nxt, s01_r, s23_r;
  logic [bcpe_pkg::ProdW:0]          sum;
  logic [bcpe_pkg::CoordW:0]         rnd;
  bcpe_pkg::bcoord_t sat;
  bcpe_pkg::coord_t  coord_nxt, coord_r;
  logic              clip_nxt, clip_r;

  // Stage 1: biased operands; the cubic factor of 3 is folded in here.
  // Quadratic reuses the slots as P0, A, P3, nothing.
  always_comb begin
    b0 = bcpe_pkg::biased(p0);
    ba = bcpe_pkg::biased(pa);
    bb = bcpe_pkg::biased(pb);
    b3 = bcpe_pkg::biased(p3);
    m1_nxt[0] = {2'b00, b0};
    if (cubic) begin
      m1_nxt[1] = bcpe_pkg::times3(ba);
      m1_nxt[2] = bcpe_pkg::times3(bb);
      m1_nxt[3] = {2'b00, b3};
    end else begin
      m1_nxt[1] = {2'b00, ba};
      m1_nxt[2] = {2'b00, b3};
      m1_nxt[3] = '0;
    end
  end

  // Stage 3: every product is bounded by the total, which fits in 64 bits.
  always_comb begin
    for (int i = 0; i < bcpe_pkg::NumTerms; i++) begin
      pr_nxt[i] = bcpe_pkg::ProdW'(wgt[i]) * bcpe_pkg::ProdW'(m2_r[i]);
    end
  end

  // Stage 4
  always_comb begin
    s01_nxt = pr_r[0] + pr_r[1] + bcpe_pkg::RoundHalf;
    s23_nxt = pr_r[2] + pr_r[3];
  end

  // Stage 5
  always_comb begin
    sum = {1'b0, s01_r} + {1'b0, s23_r};
    rnd = sum[bcpe_pkg::ProdW:bcpe_pkg::FracW];
    if (rnd[bcpe_pkg::CoordW]) begin
      sat      = bcpe_pkg::CoordMaxBiased;
      clip_nxt = 1'b1;
    end else begin
      sat      = rnd[bcpe_pkg::CoordW-1:0];
      clip_nxt = 1'b0;
    end
    coord_nxt = {~sat[bcpe_pkg::CoordW-1], sat[bcpe_pkg::CoordW-2:0]};
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      m1_r <= m1_nxt;
    end
    if (adv.s2) begin
      m2_r <= m1_r;
    end
    if (adv.s3) begin
      pr_r <= pr_nxt;
    end
    if (adv.s4) begin
      s01_r <= s01_nxt;
      s23_r <= s23_nxt;
    end
    if (adv.s5) begin
      coord_r <= coord_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign coord = coord_r;
  assign clip  = clip_r;

endmodule

`default_nettype wire

### rtl/bezier_curve_point_evaluator_unit.sv
`default_nettype none

// Quadratic/cubic Bezier point evaluator. Five register stages: (1-t) powers,
// Bernstein weights, weight-by-coordinate products, partial sums, then the final
// add with round-to-nearest (ties up) and clamp, held in the output register. A
// transaction can be accepted every cycle while the output side is not stalled. Each
// stage has its own valid bit and loads whenever it is empty or the stage after it
// moves, so a stalled output fills the pipeline bubbles before in_chan.ready drops.
// Both curve kinds share the datapath: quadratic weights are scaled by 2^16 to the
// cubic 48-bit fraction.
module bezier_curve_point_evaluator_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bcpe_in_if.sink      in_chan,
  bcpe_out_if.source   out_chan
);

  bcpe_pkg::adv_t adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [bcpe_pkg::OneMinusW-1:0] u_nxt, u_r;
  bcpe_pkg::param_t               t_r;
  logic [32:0]                    u2_nxt, u2_r;
  logic [30:0]                    ut_nxt, ut_r;
  logic [31:0]                    t2_nxt, t2_r;
  logic                           cubic_r;
  bcpe_pkg::wgt_t                 w_nxt [bcpe_pkg::NumTerms];
  bcpe_pkg::wgt_t                 w_r   [bcpe_pkg::NumTerms];
  logic                           cubic_in;
  logic                           clip_x, clip_y;

  // Stage enables: a stage takes new data when empty or when the next one moves.
  always_comb begin
    rdy5 = !v5_r || out_chan.ready;
    rdy4 = !v4_r || rdy5;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    adv  = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};
  end

  assign in_chan.ready = rdy1;
  assign cubic_in = (in_chan.req_type == bcpe_pkg::REQ_CUBIC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_chan.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  // Stage 1: u = 1 - t and the second-order terms.
  always_comb begin
    u_nxt  = 17'h10000 - {1'b0, in_chan.param_t};
    u2_nxt = 33'(u_nxt * u_nxt);
    ut_nxt = 31'(u_nxt * {1'b0, in_chan.param_t});
    t2_nxt = 32'(in_chan.param_t * in_chan.param_t);
  end

  // Stage 2: weights, all scaled to 48 fraction bits.
  always_comb begin
    if (cubic_r) begin
      w_nxt[0] = bcpe_pkg::WgtW'(u2_r * u_r);
      w_nxt[1] = bcpe_pkg::WgtW'(u2_r * t_r);
      w_nxt[2] = bcpe_pkg::WgtW'(t2_r * u_r);
      w_nxt[3] = bcpe_pkg::WgtW'(t2_r * t_r);
    end else begin
      w_nxt[0] = {u2_r, 16'h0000};
      w_nxt[1] = {1'b0, ut_r, 17'h00000};
      w_nxt[2] = {1'b0, t2_r, 16'h0000};
      w_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      u_r     <= u_nxt;
      t_r     <= in_chan.param_t;
      u2_r    <= u2_nxt;
      ut_r    <= ut_nxt;
      t2_r    <= t2_nxt;
      cubic_r <= cubic_in;
    end
    if (adv.s2) begin
      w_r <= w_nxt;
    end
  end

  bcpe_coord u_coord_x (
    .clk   (clk),
    .adv   (adv),
    .cubic (cubic_in),
    .p0    (in_chan.start_x),
    .pa    (in_chan.ctrl_a_x),
    .pb    (in_chan.ctrl_b_x),
    .p3    (in_chan.end_x),
    .wgt   (w_r),
    .coord (out_chan.point_x),
    .clip  (clip_x)
  );

  bcpe_coord u_coord_y (
    .clk   (clk),
    .adv   (adv),
    .cubic (cubic_in),
    .p0    (in_chan.start_y),
    .pa    (in_chan.ctrl_a_y),
    .pb    (in_chan.ctrl_b_y),
    .p3    (in_chan.end_y),
    .wgt   (w_r),
    .coord (out_chan.point_y),
    .clip  (clip_y)
  );

  assign out_chan.valid   = v5_r;
  assign out_chan.clipped = clip_x | clip_y;

endmodule

`default_nettype wire
